[hw/rtl/eau_pkg.sv]
// ----------------------------------------------------------------------------
// eau_pkg
// shared widths, constants and types for the encoder angle unwrapper
// ----------------------------------------------------------------------------
package eau_pkg;

  localparam int WORD_W   = 16;
  localparam int ANGLE_W  = 14;
  localparam int POS_W    = 32;
  localparam int ROT_W    = 16;
  localparam int DELTA_W  = ANGLE_W + 1;
  localparam int REV_LO_W = POS_W - ANGLE_W;

  // bit positions inside the response word
  localparam int PARITY_BIT = 15;
  localparam int ERROR_BIT  = 14;

  // full scale is 2**ANGLE_W, so a 14-bit angle never reaches it
  localparam logic [ROT_W-1:0]          MID_RANGE = 16'd8192;
  localparam logic signed [DELTA_W-1:0] JUMP_POS  = 15'sd8192;
  localparam logic signed [DELTA_W-1:0] JUMP_NEG  = -15'sd8192;

  // zero offset is kept modulo 16383
  localparam logic [ANGLE_W-1:0] ZERO_MODULUS = 14'h3FFF;

  // revolution count loaded on the first word after reset
  localparam logic [POS_W-1:0] REV_FIRST = '1;

  typedef struct packed {
    logic               frame_error;
    logic               angle_ok;
    logic [ANGLE_W-1:0] raw_angle;
  } frame_info_t;

  typedef struct packed {
    logic [POS_W-1:0]   unwrapped_position;
    logic [ROT_W-1:0]   single_turn_rotation;
    logic [ANGLE_W-1:0] accepted_angle;
    logic               frame_error;
  } unwrap_result_t;

endpackage

[hw/rtl/eau_frame_check.sv]
// ----------------------------------------------------------------------------
// eau_frame_check
// parity and error flag test of one response word, angle usability
// ----------------------------------------------------------------------------
module eau_frame_check
  import eau_pkg::*;
(
  input  logic [WORD_W-1:0] response_word,
  output frame_info_t       info
);

  logic parity_fail;

  // even parity over bits 14..0 carried in bit 15
  assign parity_fail = response_word[PARITY_BIT] ^ (^response_word[PARITY_BIT-1:0]);

  always_comb begin
    info.frame_error = response_word[ERROR_BIT] | parity_fail;
    info.raw_angle   = response_word[ANGLE_W-1:0];
    info.angle_ok    = !info.frame_error && (info.raw_angle != '0);
  end

endmodule

[hw/rtl/eau_unwrap.sv]
// ----------------------------------------------------------------------------
// eau_unwrap
// angle substitution, revolution counting and position arithmetic
// ----------------------------------------------------------------------------
module eau_unwrap
  import eau_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  frame_info_t        info,
  input  logic [ANGLE_W-1:0] zero_position,
  output unwrap_result_t     result
);

  logic [ANGLE_W-1:0]        prev_angle_r;
  logic                      seen_r;
  logic [POS_W-1:0]          rev_count_r;

  logic [ANGLE_W-1:0]        angle;
  logic [ANGLE_W-1:0]        prev_eff;
  logic [POS_W-1:0]          rev_base;
  logic [POS_W-1:0]          rev_count_nxt;
  logic signed [DELTA_W-1:0] delta;
  logic [ROT_W-1:0]          single;

  always_comb begin
    angle    = info.angle_ok ? info.raw_angle : prev_angle_r;
    // first word: no jump against itself, count starts at minus one
    prev_eff = seen_r ? prev_angle_r : angle;
    rev_base = seen_r ? rev_count_r : REV_FIRST;
    delta    = $signed({1'b0, angle}) - $signed({1'b0, prev_eff});

    priority if (delta > JUMP_POS) begin
      rev_count_nxt = rev_base - POS_W'(1);
    end else if (delta < JUMP_NEG) begin
      rev_count_nxt = rev_base + POS_W'(1);
    end else begin
      rev_count_nxt = rev_base;
    end

    single = {{(ROT_W-ANGLE_W){1'b0}}, angle} - {{(ROT_W-ANGLE_W){1'b0}}, zero_position}
             - MID_RANGE;

    result.unwrapped_position   = {rev_count_nxt[REV_LO_W-1:0], {ANGLE_W{1'b0}}}
                                  + {{(POS_W-ROT_W){single[ROT_W-1]}}, single};
    result.single_turn_rotation = single;
    result.accepted_angle       = angle;
    result.frame_error          = info.frame_error;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= '0;
      seen_r       <= 1'b0;
      rev_count_r  <= '0;
    end else if (step_en) begin
      prev_angle_r <= angle;
      seen_r       <= 1'b1;
      rev_count_r  <= rev_count_nxt;
    end
  end

endmodule

[hw/rtl/encoder_angle_unwrapper_core.sv]
// ----------------------------------------------------------------------------
// encoder_angle_unwrapper_core
// multi-turn unwrap of a 14-bit absolute encoder angle word
// ----------------------------------------------------------------------------
// path: input register, then result register, from input accept to result valid
// throughput: 1 word per cycle while the result channel is not stalled
// reset: synchronous, active low; clears both stages, angle history,
//   revolution count and zero offset; no clearing pass, ready at once
module encoder_angle_unwrapper_core
  import eau_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  // configuration: zero offset
  input  logic                    cfg_wr_en,
  input  logic [ANGLE_W-1:0]      cfg_wr_data,

  // response word channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [WORD_W-1:0]       in_response_word,

  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_unwrapped_position,
  output logic signed [ROT_W-1:0] out_single_turn_rotation,
  output logic [ANGLE_W-1:0]      out_accepted_angle,
  output logic                    out_frame_error
);

  // zero offset register, stored modulo 16383
  logic [ANGLE_W-1:0] zero_r;

  // input stage
  logic               s1_valid_r;
  logic [WORD_W-1:0]  s1_word_r;

  // result stage
  logic               out_valid_r;
  unwrap_result_t     out_r;

  logic               advance;
  logic               in_accept;
  frame_info_t        info;
  unwrap_result_t     result;

  // result register frees up when empty or being taken
  assign advance   = !out_valid_r || !out_stall;
  // input register takes a word whenever it is empty or its contents move on this cycle
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= '0;
    end else if (cfg_wr_en) begin
      // all-ones offset wraps to zero
      zero_r <= (cfg_wr_data == ZERO_MODULUS) ? '0 : cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance || !s1_valid_r) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_response_word;
    end
  end

  eau_frame_check u_frame_check (
    .response_word (s1_word_r),
    .info          (info)
  );

  // angle history and revolution count move only when a word passes to the result
  eau_unwrap u_unwrap (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (s1_valid_r && advance),
    .info          (info),
    .zero_position (zero_r),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_r <= result;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_unwrapped_position   = $signed(out_r.unwrapped_position);
  assign out_single_turn_rotation = $signed(out_r.single_turn_rotation);
  assign out_accepted_angle       = out_r.accepted_angle;
  assign out_frame_error          = out_r.frame_error;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // an empty input stage never holds off the source
  a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled while input stage empty");

  // a word leaving the input stage always lands in the result register
  a_advance_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("word lost between stages");

  // a clean nonzero angle is passed through unchanged
  a_clean_angle_used : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && info.angle_ok)
      |=> (out_accepted_angle == $past(info.raw_angle)))
    else $error("clean angle was substituted");

endmodule

[tb/eau_checker.sv]
// ----------------------------------------------------------------------------
// eau_checker
// watches both word channels of the unwrapper, predicts each result word and
// compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module eau_checker
  import eau_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [ANGLE_W-1:0]      cfg_wr_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [WORD_W-1:0]       in_response_word,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [POS_W-1:0] out_unwrapped_position,
  input  logic signed [ROT_W-1:0] out_single_turn_rotation,
  input  logic [ANGLE_W-1:0]      out_accepted_angle,
  input  logic                    out_frame_error,
  output int                      mismatch_count,
  output int                      pending_words,
  output int                      checked_words,
  output int                      flagged_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_COUNTS = int'(MID_RANGE);

  logic [ANGLE_W-1:0] zero_offset;
  logic [ANGLE_W-1:0] last_angle;
  logic               started;
  logic [POS_W-1:0]   turns;
  unwrap_result_t     expected_q[$];

  // one response word through the unwrap, updating the angle history
  function automatic void unwrap_word(input logic [WORD_W-1:0] w, output unwrap_result_t r);
    logic               bad;
    logic [ANGLE_W-1:0] ang;
    int                 diff;
    logic [POS_W-1:0]   turn;
    bad = w[ERROR_BIT] | (w[PARITY_BIT] ^ (^w[PARITY_BIT-1:0]));
    ang = w[ANGLE_W-1:0];
    // a 14-bit angle never reaches full scale, so only zero is unusable
    if (bad || ang == '0) ang = last_angle;
    if (!started) begin
      started    = 1'b1;
      last_angle = ang;
      turns      = REV_FIRST;
    end
    diff = int'(ang) - int'(last_angle);
    if (diff > HALF_COUNTS) turns = turns - 1'b1;
    else if (diff < -HALF_COUNTS) turns = turns + 1'b1;
    last_angle = ang;
    turn = POS_W'(ang) - POS_W'(zero_offset) - POS_W'(HALF_COUNTS);
    r.unwrapped_position   = (turns << ANGLE_W) + turn;
    r.single_turn_rotation = turn[ROT_W-1:0];
    r.accepted_angle       = ang;
    r.frame_error          = bad;
  endfunction

  always @(posedge clk) begin
    unwrap_result_t want;
    unwrap_result_t got;
    if (!rst_n) begin
      zero_offset    = '0;
      last_angle     = '0;
      started        = 1'b0;
      turns          = '0;
      mismatch_count = 0;
      checked_words  = 0;
      flagged_words  = 0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) zero_offset = cfg_wr_data % ZERO_MODULUS;
      // compare before queueing, so an early result cannot meet its own word
      if (out_valid && !out_stall) begin
        got = '{out_unwrapped_position, out_single_turn_rotation,
                out_accepted_angle, out_frame_error};
        checked_words++;
        if (got.frame_error) flagged_words++;
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%t: result word with none expected: pos %0d rot %0d ang %0d err %0b",
                     $realtime, $signed(got.unwrapped_position),
                     $signed(got.single_turn_rotation), got.accepted_angle, got.frame_error);
        end else begin
          want = expected_q.pop_front();
          if (got.unwrapped_position !== want.unwrapped_position ||
              got.single_turn_rotation !== want.single_turn_rotation ||
              got.accepted_angle !== want.accepted_angle ||
              got.frame_error !== want.frame_error) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%t: mismatch exp pos %0d rot %0d ang %0d err %0b",
                        " / got pos %0d rot %0d ang %0d err %0b"},
                       $realtime, $signed(want.unwrapped_position),
                       $signed(want.single_turn_rotation), want.accepted_angle,
                       want.frame_error, $signed(got.unwrapped_position),
                       $signed(got.single_turn_rotation), got.accepted_angle,
                       got.frame_error);
          end
        end
      end
      if (in_valid && !in_stall) begin
        unwrap_word(in_response_word, want);
        expected_q.push_back(want);
      end
    end
    pending_words <= expected_q.size();
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for encoder_angle_unwrapper_core: directed corner
// words, random angle walks under several zero offsets, and a short steady
// spin that counts turns; results checked by eau_checker
// ----------------------------------------------------------------------------
module testbench
  import eau_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // two register stages in the block, plus a little slack
  localparam int DRAIN_CYCLES = 4;
  // turns in the steady spin, three words each
  localparam int SPIN_TURNS   = 30;
  localparam int IDLE_PERCENT = 28;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [ANGLE_W-1:0]      cfg_wr_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [WORD_W-1:0]       in_response_word;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [POS_W-1:0] out_unwrapped_position;
  logic signed [ROT_W-1:0] out_single_turn_rotation;
  logic [ANGLE_W-1:0]      out_accepted_angle;
  logic                    out_frame_error;

  int mismatch_count;
  int pending_words;
  int checked_words;
  int flagged_words;

  // stimulus knobs shared between the sender and receiver processes
  bit                 tx_idle_on;
  bit                 rx_idle_on;
  int                 hold_left;
  int                 offsets_written;
  int                 random_words;
  logic [ANGLE_W-1:0] walk;

  encoder_angle_unwrapper_core DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_wr_en                (cfg_wr_en),
    .cfg_wr_data              (cfg_wr_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_response_word         (in_response_word),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_unwrapped_position   (out_unwrapped_position),
    .out_single_turn_rotation (out_single_turn_rotation),
    .out_accepted_angle       (out_accepted_angle),
    .out_frame_error          (out_frame_error)
  );

  eau_checker u_checker (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_wr_en                (cfg_wr_en),
    .cfg_wr_data              (cfg_wr_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_response_word         (in_response_word),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_unwrapped_position   (out_unwrapped_position),
    .out_single_turn_rotation (out_single_turn_rotation),
    .out_accepted_angle       (out_accepted_angle),
    .out_frame_error          (out_frame_error),
    .mismatch_count           (mismatch_count),
    .pending_words            (pending_words),
    .checked_words            (checked_words),
    .flagged_words            (flagged_words)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2ms;
    $display("testbench failed");
    $finish;
  end

  // receiver: random stall, or a long hold-off counted down here
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // frame builder: even parity over bits 14..0, optionally broken
  function automatic logic [WORD_W-1:0] make_word(input logic err,
                                                  input logic [ANGLE_W-1:0] ang,
                                                  input logic flip);
    return {(^{err, ang}) ^ flip, err, ang};
  endfunction

  // offer one word, with random idle cycles ahead of it, until accepted
  task automatic send_word(input logic [WORD_W-1:0] w);
    while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_response_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // let every expected word come back, then allow the pipe to settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // zero offset write, only ever issued with the block drained
  task automatic write_zero(input logic [ANGLE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    offsets_written++;
  endtask

  // mostly plausible encoder motion, with bad frames and raw noise mixed in
  task automatic random_run(input int count, input int pause_at);
    int                 pick;
    int                 dir;
    logic [WORD_W-1:0]  w;
    dir = 1;
    for (int i = 0; i < count; i++) begin
      // sender waits here until the block has handed back everything
      if (i == pause_at) drain();
      pick = $urandom_range(99);
      if (pick < 40) begin
        walk = walk + ANGLE_W'($urandom_range(2000)) - ANGLE_W'(1000);
        w = make_word(1'b0, walk, 1'b0);
      end else if (pick < 65) begin
        // steady rotation; large steps so wrap-arounds count turns
        if ($urandom_range(15) == 0) dir = -dir;
        walk = walk + ANGLE_W'(dir * int'($urandom_range(7000, 3000)));
        w = make_word(1'b0, walk, 1'b0);
      end else if (pick < 75) begin
        walk = ANGLE_W'($urandom);
        w = make_word(1'b0, walk, 1'b0);
      end else if (pick < 83) begin
        w = make_word(1'b1, ANGLE_W'($urandom), 1'b0);
      end else if (pick < 89) begin
        w = make_word(1'b0, ANGLE_W'($urandom), 1'b1);
      end else if (pick < 93) begin
        w = make_word(1'b0, '0, 1'b0);
      end else begin
        w = WORD_W'($urandom);
      end
      send_word(w);
      random_words++;
    end
  endtask

  initial begin
    logic [WORD_W-1:0] opening[20];
    int                jit;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_response_word <= '0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    hold_left        = 0;
    offsets_written  = 0;
    random_words     = 0;
    walk             = 14'd4000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // offset of full modulus folds back to zero
    write_zero(14'h3FFF);

    opening = '{
      make_word(1'b1, 14'h1234, 1'b0), // bad first word: angle falls back to zero
      make_word(1'b0, 14'd1, 1'b0),
      make_word(1'b0, 14'h3FFF, 1'b0), // jump up past half scale, turn down
      make_word(1'b0, 14'd1, 1'b0),    // and back, turn up
      make_word(1'b0, 14'd0, 1'b0),    // zero angle keeps the last one
      make_word(1'b0, 14'd100, 1'b0),
      make_word(1'b0, 14'd8292, 1'b0), // exactly half scale, no turn
      make_word(1'b0, 14'd99, 1'b0),   // one past half scale down
      make_word(1'b0, 14'd8292, 1'b0), // one past half scale up
      make_word(1'b0, 14'd100, 1'b0),  // exactly half scale down
      make_word(1'b0, 14'h2AAA, 1'b1), // parity broken
      make_word(1'b1, 14'h1555, 1'b0), // sensor error flag
      16'hFFFF,
      16'h0000,
      16'h8000,
      16'h7FFF,
      make_word(1'b0, 14'h3FFF, 1'b0),
      make_word(1'b0, 14'h2000, 1'b0),
      make_word(1'b0, 14'h1FFF, 1'b0),
      16'h4000
    };
    foreach (opening[k]) send_word(opening[k]);
    drain();

    // largest offset: single-turn rotation at its low end
    write_zero(14'd16382);
    send_word(make_word(1'b0, 14'd1, 1'b0));
    send_word(make_word(1'b0, 14'h3FFF, 1'b0));
    send_word(make_word(1'b0, 14'd8192, 1'b0));
    drain();

    // receiver holds off at the start so the block backs up into the sender
    write_zero(14'd0);
    hold_left = 150;
    random_run(200, -1);
    drain();

    // sender pauses halfway until the pipe is empty
    write_zero(ANGLE_W'($urandom));
    random_run(200, 100);
    drain();

    // back to back, no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_zero(14'd8191);
    random_run(200, -1);
    drain();

    // spin one way, three words a turn
    write_zero(ANGLE_W'($urandom));
    for (int t = 0; t < SPIN_TURNS; t++) begin
      jit = $urandom_range(63);
      send_word(make_word(1'b0, ANGLE_W'(1 + jit), 1'b0));
      send_word(make_word(1'b0, ANGLE_W'(5462 + jit), 1'b0));
      send_word(make_word(1'b0, ANGLE_W'(10923 + jit), 1'b0));
    end
    drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    write_zero(ANGLE_W'($urandom_range(16383)));
    random_run(100, -1);
    drain();

    $display("run covered %0d result words (%0d flagged bad), %0d offset writes",
             checked_words, flagged_words, offsets_written);
    $display("  corner frames, %0d random words, %0d-turn steady spin",
             random_words, SPIN_TURNS);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[encoder_angle_unwrapper_core.f]
hw/rtl/eau_pkg.sv
hw/rtl/eau_frame_check.sv
hw/rtl/eau_unwrap.sv
hw/rtl/encoder_angle_unwrapper_core.sv
tb/eau_checker.sv
tb/testbench.sv
